@@ design/ihb_pkg.sv @@
// ----------------------------------------------------------------------------
// ihb_pkg: indexed binary heap shared definitions
// Sizes, slot and position types, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ihb_pkg;

  localparam int CAPACITY       = 64;
  localparam int PRIORITY_WIDTH = 32;
  localparam int ID_W           = 6;
  localparam int ID_COUNT       = 1 << ID_W;
  localparam int POS_W          = $clog2(CAPACITY + 1);
  localparam int SLOT_AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SLOT_W         = ID_W + PRIORITY_WIDTH;

  typedef logic signed [PRIORITY_WIDTH-1:0] prio_t;
  typedef logic [ID_W-1:0]                  id_t;
  typedef logic [POS_W-1:0]                 pos_t;
  typedef logic [SLOT_AW-1:0]               slot_addr_t;

  typedef struct packed {
    id_t   id;
    prio_t pri;
  } slot_t;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;
  localparam logic [1:0] CMD_UPDATE = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NO_ID   = 3'd3;
  localparam logic [2:0] ST_DUP_ID  = 3'd4;

  // heap slot k (1-based) lives at RAM address k-1
  function automatic slot_addr_t slot_addr(input pos_t p);
    pos_t d;
    d = p - POS_W'(1);
    return SLOT_AW'(d);
  endfunction

  function automatic prio_t to_prio(input logic signed [31:0] p);
    return prio_t'(p);
  endfunction

  function automatic logic signed [31:0] to_out_pri(input prio_t p);
    return 32'(p);
  endfunction

endpackage

`default_nettype wire

@@ design/ihb_if.sv @@
// ----------------------------------------------------------------------------
// ihb_if: heap command and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [5:0]         item_id;
  logic signed [31:0] priority_in;

  modport source (output valid, command, item_id, priority_in, input ready);
  modport sink   (input valid, command, item_id, priority_in, output ready);
endinterface

interface ihb_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [5:0]         top_id;
  logic signed [31:0] top_priority;
  logic [6:0]         entry_count;

  modport source (output valid, status, top_id, top_priority, entry_count, input ready);
  modport sink   (input valid, status, top_id, top_priority, entry_count, output ready);
endinterface

`default_nettype wire

@@ design/indexed_binary_heap.sv @@
// ----------------------------------------------------------------------------
// indexed_binary_heap: indexed priority queue on a one-based binary heap
// Sequence: peek and errors answer from the decode state; push and update up
// read and compare the parent per level climbed; pop and update down read the left
// child, read the right child and compare per level, then end with one final write.
// Throughput: one item at a time, set by the single slot RAM read port and the
// result register that must empty first.
// Reset: empty heap, all ids absent (per-id valid flops), max-heap mode.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_binary_heap (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ihb_in_if.sink     in_ch,
  ihb_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);
  import ihb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_UPD_RD, S_POP_LAST, S_UP_CHK,
    S_UP_CMP, S_DN_L, S_DN_R, S_DN_CMP, S_WR_MV
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0] cmd_r, cmd_nxt;
  id_t        id_r, id_nxt;
  prio_t      pri_r, pri_nxt;
  pos_t       fill_r, fill_nxt;
  pos_t       pos_r, pos_nxt;        // current hole position
  slot_t      mv_r, mv_nxt;          // entry being sifted
  slot_t      cand_r, cand_nxt;      // left child during sift down
  pos_t       cand_pos_r, cand_pos_nxt;
  logic       left_better_r, left_better_nxt;
  logic       has_right_r, has_right_nxt;
  logic       pm_vld_q_r, pm_vld_q_nxt;
  logic       pm_valid_r [ID_COUNT];
  logic       pm_valid_nxt [ID_COUNT];
  logic       mode_r, mode_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] status_r, status_nxt;
  id_t        top_id_r, top_id_nxt;
  prio_t      top_pri_r, top_pri_nxt;

  // slot RAM (heap array) and position map RAM
  logic       sl_we;
  slot_addr_t sl_waddr, sl_raddr;
  slot_t      sl_wdata, sl_rdata;
  logic       pm_we;
  id_t        pm_waddr, pm_raddr;
  pos_t       pm_wdata, pm_rdata;

  // shared compare unit
  prio_t      cmp_a, cmp_b;
  logic       cmp_better;

  pos_t             pm_pos;
  logic [POS_W:0]   left_pos;
  prio_t            best_pri;

  ihb_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  ihb_ram #(.WIDTH(POS_W), .DEPTH(ID_COUNT)) u_pos_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  ihb_cmp u_cmp (
    .mode   (mode_r),
    .a      (cmp_a),
    .b      (cmp_b),
    .better (cmp_better)
  );

  assign in_ch.ready         = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.top_id       = top_id_r;
  assign out_ch.top_priority = to_out_pri(top_pri_r);
  assign out_ch.entry_count  = 7'(fill_r);

  // a position read back as absent unless the id was ever written
  assign pm_pos   = pm_vld_q_r ? pm_rdata : '0;
  assign left_pos = {pos_r, 1'b0};
  assign best_pri = left_better_r ? cand_r.pri : mv_r.pri;

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    id_nxt          = id_r;
    pri_nxt         = pri_r;
    fill_nxt        = fill_r;
    pos_nxt         = pos_r;
    mv_nxt          = mv_r;
    cand_nxt        = cand_r;
    cand_pos_nxt    = cand_pos_r;
    left_better_nxt = left_better_r;
    has_right_nxt   = has_right_r;
    pm_vld_q_nxt    = pm_vld_q_r;
    pm_valid_nxt    = pm_valid_r;
    mode_nxt        = mode_r;
    out_valid_nxt   = out_valid_r;
    status_nxt      = status_r;
    top_id_nxt      = top_id_r;
    top_pri_nxt     = top_pri_r;

    sl_we    = 1'b0;
    sl_waddr = slot_addr(pos_r);
    sl_wdata = mv_r;
    sl_raddr = '0;
    pm_we    = 1'b0;
    pm_waddr = mv_r.id;
    pm_wdata = pos_r;
    pm_raddr = in_ch.item_id;
    cmp_a    = mv_r.pri;
    cmp_b    = sl_rdata.pri;

    if (cfg_we) begin
      mode_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          cmd_nxt      = in_ch.command;
          id_nxt       = in_ch.item_id;
          pri_nxt      = to_prio(in_ch.priority_in);
          pm_vld_q_nxt = pm_valid_r[in_ch.item_id];
          status_nxt   = ST_OK;
          top_id_nxt   = '0;
          top_pri_nxt  = '0;
          sl_raddr     = slot_addr(POS_W'(1));   // root, for pop and peek
          state_nxt    = S_DECODE;
        end
      end

      S_DECODE: begin
        case (cmd_r)
          CMD_PUSH: begin
            if (fill_r == POS_W'(CAPACITY)) begin
              status_nxt    = ST_FULL;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else if (pm_pos != '0) begin
              status_nxt    = ST_DUP_ID;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              fill_nxt  = fill_r + POS_W'(1);
              pos_nxt   = fill_r + POS_W'(1);
              mv_nxt    = '{id: id_r, pri: pri_r};
              state_nxt = S_UP_CHK;
            end
          end
          CMD_POP, CMD_PEEK: begin
            if (fill_r == '0) begin
              status_nxt    = ST_EMPTY;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              top_id_nxt  = sl_rdata.id;
              top_pri_nxt = sl_rdata.pri;
              if (cmd_r == CMD_PEEK) begin
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end else begin
                // popped id leaves the map
                pm_we    = 1'b1;
                pm_waddr = sl_rdata.id;
                pm_wdata = '0;
                fill_nxt = fill_r - POS_W'(1);
                if (fill_r == POS_W'(1)) begin
                  out_valid_nxt = 1'b1;
                  state_nxt     = S_IDLE;
                end else begin
                  sl_raddr  = slot_addr(fill_r);
                  state_nxt = S_POP_LAST;
                end
              end
            end
          end
          default: begin   // update
            if (pm_pos == '0 || pm_pos > fill_r) begin
              status_nxt    = ST_NO_ID;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              pos_nxt   = pm_pos;
              sl_raddr  = slot_addr(pm_pos);
              state_nxt = S_UPD_RD;
            end
          end
        endcase
      end

      S_UPD_RD: begin
        cmp_a = pri_r;
        cmp_b = sl_rdata.pri;
        if (sl_rdata.pri == pri_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mv_nxt    = '{id: id_r, pri: pri_r};
          state_nxt = cmp_better ? S_UP_CHK : S_DN_L;
        end
      end

      S_POP_LAST: begin
        // last entry moves to the root
        mv_nxt    = sl_rdata;
        pos_nxt   = POS_W'(1);
        state_nxt = S_DN_L;
      end

      S_UP_CHK: begin
        if (pos_r == POS_W'(1)) begin
          state_nxt = S_WR_MV;
        end else begin
          sl_raddr  = slot_addr(pos_r >> 1);
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmp_a = mv_r.pri;
        cmp_b = sl_rdata.pri;
        if (cmp_better) begin
          // parent drops into the hole
          sl_we     = 1'b1;
          sl_wdata  = sl_rdata;
          pm_we     = 1'b1;
          pm_waddr  = sl_rdata.id;
          pos_nxt   = pos_r >> 1;
          state_nxt = S_UP_CHK;
        end else begin
          state_nxt = S_WR_MV;
        end
      end

      S_DN_L: begin
        if (left_pos > {1'b0, fill_r}) begin
          state_nxt = S_WR_MV;
        end else begin
          sl_raddr      = slot_addr(POS_W'(left_pos));
          cand_pos_nxt  = POS_W'(left_pos);
          has_right_nxt = (left_pos < {1'b0, fill_r});
          state_nxt     = S_DN_R;
        end
      end

      S_DN_R: begin
        cand_nxt        = sl_rdata;
        cmp_a           = sl_rdata.pri;
        cmp_b           = mv_r.pri;
        left_better_nxt = cmp_better;
        sl_raddr        = slot_addr(cand_pos_r + POS_W'(1));
        state_nxt       = S_DN_CMP;
      end

      S_DN_CMP: begin
        // right wins only if strictly better than the current best
        cmp_a = sl_rdata.pri;
        cmp_b = best_pri;
        if (has_right_r && cmp_better) begin
          sl_we     = 1'b1;
          sl_wdata  = sl_rdata;
          pm_we     = 1'b1;
          pm_waddr  = sl_rdata.id;
          pos_nxt   = cand_pos_r + POS_W'(1);
          state_nxt = S_DN_L;
        end else if (left_better_r) begin
          sl_we     = 1'b1;
          sl_wdata  = cand_r;
          pm_we     = 1'b1;
          pm_waddr  = cand_r.id;
          pos_nxt   = cand_pos_r;
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_WR_MV;
        end
      end

      S_WR_MV: begin
        sl_we         = 1'b1;
        pm_we         = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (pm_we) begin
      pm_valid_nxt[pm_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      mode_r      <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ID_COUNT; i++) begin
        pm_valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      pm_valid_r  <= pm_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    id_r          <= id_nxt;
    pri_r         <= pri_nxt;
    pos_r         <= pos_nxt;
    mv_r          <= mv_nxt;
    cand_r        <= cand_nxt;
    cand_pos_r    <= cand_pos_nxt;
    left_better_r <= left_better_nxt;
    has_right_r   <= has_right_nxt;
    pm_vld_q_r    <= pm_vld_q_nxt;
    status_r      <= status_nxt;
    top_id_r      <= top_id_nxt;
    top_pri_r     <= top_pri_nxt;
  end

endmodule

`default_nettype wire

@@ design/ihb_ram.sv @@
// ----------------------------------------------------------------------------
// ihb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ihb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/ihb_cmp.sv @@
// ----------------------------------------------------------------------------
// ihb_cmp: priority compare unit
// True when a ranks strictly ahead of b in the current heap order.
// ----------------------------------------------------------------------------
`default_nettype none

module ihb_cmp (
  input  wire logic          mode,
  input  wire ihb_pkg::prio_t a,
  input  wire ihb_pkg::prio_t b,
  output logic               better
);
  import ihb_pkg::*;

  always_comb begin
    if (mode) begin
      better = (a > b);
    end else begin
      better = (a < b);
    end
  end

endmodule

`default_nettype wire

@@ tb/ihb_tb_if.sv @@
// ----------------------------------------------------------------------------
// ihb_tb_if: testbench-side notes on the heap channels
// The channel interfaces come from the design; this file only carries the
// item types the testbench uses to record commands and results.
// ----------------------------------------------------------------------------
`default_nettype none

package ihb_tb_pkg;
  import ihb_pkg::*;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         item_id;
    logic signed [31:0] priority_in;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         top_id;
    logic signed [31:0] top_priority;
    logic [6:0]         entry_count;
  } heap_result_t;
endpackage

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: indexed binary heap testbench
// Drives push/pop/peek/update commands over the valid/ready channel, keeps
// its own model of the heap and position map, and checks every result item
// field by field. Runs with both heap orders and random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

import ihb_pkg::*;
import ihb_tb_pkg::*;

// Heap predictor plus queue of expected result items.
class heap_scoreboard;
  logic signed [31:0] pri_at [1:CAPACITY];
  logic [5:0]         id_at  [1:CAPACITY];
  int                 where_is [ID_COUNT];
  int                 fill;
  bit                 max_mode;
  heap_result_t       pending [$];
  int                 mismatches;
  int                 checked;

  function new();
    foreach (where_is[i]) where_is[i] = 0;
    fill = 0;
    max_mode = 1;
    mismatches = 0;
    checked = 0;
  endfunction

  function bit beats(logic signed [31:0] a, logic signed [31:0] b);
    return max_mode ? (a > b) : (a < b);
  endfunction

  function void exchange(int i, int j);
    logic signed [31:0] p;
    logic [5:0]         d;
    p = pri_at[i]; d = id_at[i];
    pri_at[i] = pri_at[j]; id_at[i] = id_at[j];
    pri_at[j] = p; id_at[j] = d;
    where_is[id_at[i]] = i;
    where_is[id_at[j]] = j;
  endfunction

  function void climb(int pos);
    while (pos > 1 && beats(pri_at[pos], pri_at[pos/2])) begin
      exchange(pos, pos/2);
      pos = pos / 2;
    end
  endfunction

  function void sink_down(int pos);
    int l, r, best;
    forever begin
      l = 2*pos; r = l+1; best = pos;
      if (l > fill) break;
      if (beats(pri_at[l], pri_at[best])) best = l;
      if (r <= fill && beats(pri_at[r], pri_at[best])) best = r;
      if (best == pos) break;
      exchange(pos, best);
      pos = best;
    end
  endfunction

  // Apply one accepted command and queue the result it must produce.
  function void note_command(cmd_item_t c);
    heap_result_t res;
    int pos;
    logic signed [31:0] old;
    res = '0;
    case (c.command)
      CMD_PUSH: begin
        if (fill >= CAPACITY) res.status = ST_FULL;
        else if (where_is[c.item_id] != 0) res.status = ST_DUP_ID;
        else begin
          fill++;
          pri_at[fill] = c.priority_in;
          id_at[fill] = c.item_id;
          where_is[c.item_id] = fill;
          climb(fill);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (fill == 0) res.status = ST_EMPTY;
        else begin
          res.top_id = id_at[1];
          res.top_priority = pri_at[1];
          if (c.command == CMD_POP) begin
            if (fill > 1) exchange(1, fill);
            where_is[res.top_id] = 0;
            fill--;
            sink_down(1);
          end
        end
      end
      default: begin
        pos = where_is[c.item_id];
        if (pos == 0 || pos > fill) res.status = ST_NO_ID;
        else begin
          old = pri_at[pos];
          if (old != c.priority_in) begin
            pri_at[pos] = c.priority_in;
            if (beats(c.priority_in, old)) climb(pos);
            else sink_down(pos);
          end
        end
      end
    endcase
    res.entry_count = 7'(fill);
    pending.push_back(res);
  endfunction

  function void check_result(heap_result_t got);
    heap_result_t want;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected st=%0d id=%0d pri=%0d cnt=%0d, %s",
                 want.status, want.top_id, want.top_priority, want.entry_count,
                 $sformatf("got st=%0d id=%0d pri=%0d cnt=%0d",
                           got.status, got.top_id, got.top_priority,
                           got.entry_count));
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  ihb_in_if  in_ch();
  ihb_out_if out_ch();

  indexed_binary_heap dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  heap_scoreboard board = new();

  // idle percentages for sender and receiver; hold_cycles forces a long stall
  int  send_idle = 0;
  int  recv_idle = 0;
  int  hold_cycles = 0;
  int  sent = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.command = CMD_PEEK;
    in_ch.item_id = 0;
    in_ch.priority_in = 0;
    out_ch.ready = 0;
  end

  // Receiver: ready toggles at the falling edge; results sampled at the rise.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    heap_result_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.status = out_ch.status;
      r.top_id = out_ch.top_id;
      r.top_priority = out_ch.top_priority;
      r.entry_count = out_ch.entry_count;
      board.check_result(r);
    end
  end

  // Offer one item; holds valid until accepted, models it on acceptance.
  // Valid stays up after return; drain() lowers it, as does a next call that idles.
  task automatic send_cmd(logic [1:0] c, logic [5:0] id, logic signed [31:0] p);
    cmd_item_t item;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    item.command = c; item.item_id = id; item.priority_in = p;
    in_ch.valid <= 1;
    in_ch.command <= c;
    in_ch.item_id <= id;
    in_ch.priority_in <= p;
    do @(posedge clk); while (!in_ch.ready);
    board.note_command(item);
    sent++;
    @(negedge clk);
  endtask

  // Wait for the heap to drain its expected results, then a little slack.
  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_mode(bit m);
    drain();
    cfg_we <= 1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 0;
    board.max_mode = m;
  endtask

  // Priority with frequent extremes and ties.
  function automatic logic signed [31:0] pick_pri();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed(32'($urandom_range(7))) - 3;
      default: return $signed($urandom());
    endcase
  endfunction

  // Random phase: pushes favored while small, pops while large.
  task automatic random_phase(int n);
    int k;
    int roll;
    logic [5:0] id;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      id = (board.fill > 0 && $urandom_range(3) != 0) ?
           board.id_at[$urandom_range(board.fill, 1)] : 6'($urandom());
      if (roll < 40 - board.fill / 3)
        send_cmd(CMD_PUSH, ($urandom_range(3) == 0) ? id : 6'($urandom()), pick_pri());
      else if (roll < 60)
        send_cmd(CMD_POP, 6'($urandom()), $signed($urandom()));
      else if (roll < 70)
        send_cmd(CMD_PEEK, 6'($urandom()), $signed($urandom()));
      else
        send_cmd(CMD_UPDATE, id, pick_pri());
    end
  endtask

  initial begin
    int i;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: empty cases, extremes, ties, all commands, both orders.
    send_cmd(CMD_POP, 6'd0, 0);
    send_cmd(CMD_PEEK, 6'd63, 0);
    send_cmd(CMD_UPDATE, 6'd5, 0);
    send_cmd(CMD_PUSH, 6'd63, 32'sh7fffffff);
    send_cmd(CMD_PUSH, 6'd0, 32'sh80000000);
    send_cmd(CMD_PUSH, 6'd1, 32'sh7fffffff);
    send_cmd(CMD_PUSH, 6'd1, 5);
    send_cmd(CMD_PUSH, 6'd2, 7);
    send_cmd(CMD_PUSH, 6'd3, 7);
    send_cmd(CMD_UPDATE, 6'd2, 7);
    send_cmd(CMD_UPDATE, 6'd63, -1);
    send_cmd(CMD_UPDATE, 6'd0, 32'sh7fffffff);
    send_cmd(CMD_PEEK, 6'd0, 0);
    send_cmd(CMD_POP, 6'd0, 0);
    set_mode(0);
    send_cmd(CMD_PUSH, 6'd10, -100);
    send_cmd(CMD_POP, 6'd0, 0);
    send_cmd(CMD_UPDATE, 6'd1, 32'sh80000000);
    while (board.fill > 0) send_cmd(CMD_POP, 6'd0, 0);
    // fill to capacity then overflow, with an already present id too
    for (i = 0; i < CAPACITY; i++) send_cmd(CMD_PUSH, 6'(i), $signed($urandom()));
    send_cmd(CMD_PUSH, 6'd7, 0);
    send_cmd(CMD_PUSH, 6'd40, 1);
    set_mode(1);
    send_cmd(CMD_POP, 6'd0, 0);

    // Long receiver stall while commands keep arriving.
    hold_cycles = 400;
    for (i = 0; i < 20; i++) send_cmd(CMD_PEEK, 6'd0, 0);

    send_idle = 24; recv_idle = 70;
    random_phase(550);
    set_mode(0);
    send_idle = 70; recv_idle = 24;
    random_phase(550);
    set_mode(1);
    send_idle = 0; recv_idle = 0;
    random_phase(550);
    drain();

    $display("covered %0d commands in both heap orders, full and empty heap,", sent);
    $display("%0d results checked", board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("tb NOT OK");
    $finish;
  end
endmodule

`default_nettype wire

@@ indexed_binary_heap.f @@
design/ihb_pkg.sv
design/ihb_if.sv
design/ihb_ram.sv
design/ihb_cmp.sv
design/indexed_binary_heap.sv
tb/ihb_tb_if.sv
tb/tb.sv
